### hdl/verlet_pair_list_with_skin_check_macros.svh
// Assertion helpers included by vpl_back; clk and rst are taken from the module.
`ifndef VERLET_PAIR_LIST_WITH_SKIN_CHECK_MACROS_SVH
`define VERLET_PAIR_LIST_WITH_SKIN_CHECK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VPL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/vpl_pkg.sv
`timescale 1ns / 1ps
package vpl_pkg;

  localparam int IDX_W      = 6;
  localparam int POS_W      = 32;
  localparam int BOX_W      = 31;
  localparam int LEN_W      = 30;
  localparam int TOTAL_W    = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam int DISP_W     = 32;
  localparam int D2_W       = 64;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_CHECK = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [1:0] KIND_PAIR    = 2'd0;
  localparam logic [1:0] KIND_ROW     = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 3'd5;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [POS_W-1:0] pz;
    logic             sweep_end;
  } item_t;

  typedef struct packed {
    logic [BOX_W-1:0]   box_x;
    logic [BOX_W-1:0]   box_y;
    logic [BOX_W-1:0]   box_z;
    logic [LEN_W-1:0]   cutoff;
    logic [LEN_W-1:0]   skin;
    logic [TOTAL_W-1:0] total;
  } cfg_t;

endpackage

### hdl/verlet_pair_list_with_skin_check.sv
`timescale 1ns / 1ps
// Neighbor pair list with skin check, positions in Q16.16.
// Input words (in_valid/in_ready) carry a mode, a particle index, a position
// and a sweep end flag. Mode 0 loads a position, mode 1 scans one row of the
// pair list, mode 2 checks one particle's drift from its reference position.
// Result words (out_valid/out_ready) carry pairs, a row-done word, or the
// rebuild verdict at the end of a check sweep; last marks each word's final result.
// In a row, each later particle's pair goes through three minimum-image
// remainder units that retire one bit of the coordinate difference per cycle.
// A check uses the remainder units and the one-bit-per-cycle square root.
// A two-word queue sits between the input port and the sequencer, so new
// words are taken while a result waits. When the receiver stalls, the
// sequencer holds its result and stops; the queue then fills and in_ready drops.
// Reset (rst, synchronous) restores the registers to their defaults and clears
// the two largest displacements; position stores are undefined until loaded.
// Configuration is written with cfg_we/cfg_index/cfg_data while idle.
module verlet_pair_list_with_skin_check #(
  parameter int MAX_PARTICLES = 64,
  parameter int COORD_BITS    = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [vpl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vpl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     mode,
  input  logic [vpl_pkg::IDX_W-1:0]      particle_index,
  input  logic signed [vpl_pkg::POS_W-1:0] pos_x,
  input  logic signed [vpl_pkg::POS_W-1:0] pos_y,
  input  logic signed [vpl_pkg::POS_W-1:0] pos_z,
  input  logic                           sweep_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     kind,
  output logic [vpl_pkg::IDX_W-1:0]      first_index,
  output logic [vpl_pkg::IDX_W-1:0]      second_index,
  output logic                           rebuild_needed,
  output logic                           last
);
  import vpl_pkg::*;

  cfg_t  cfg;
  item_t head;
  logic  head_valid;
  logic  pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_x  <= BOX_W'(655360);
      cfg.box_y  <= BOX_W'(655360);
      cfg.box_z  <= BOX_W'(655360);
      cfg.cutoff <= LEN_W'(163840);
      cfg.skin   <= LEN_W'(19661);
      cfg.total  <= TOTAL_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOX_X:  cfg.box_x  <= cfg_data;
        CFG_BOX_Y:  cfg.box_y  <= cfg_data;
        CFG_BOX_Z:  cfg.box_z  <= cfg_data;
        CFG_CUTOFF: cfg.cutoff <= cfg_data[LEN_W-1:0];
        CFG_SKIN:   cfg.skin   <= cfg_data[LEN_W-1:0];
        CFG_TOTAL:  cfg.total  <= cfg_data[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  vpl_front #(.MAX_PARTICLES(MAX_PARTICLES)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
    .particle_index(particle_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .sweep_end(sweep_end), .head_valid(head_valid), .head(head), .pop(pop)
  );

  vpl_back #(.MAX_PARTICLES(MAX_PARTICLES), .COORD_BITS(COORD_BITS)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .head_valid(head_valid), .head(head), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .first_index(first_index),
    .second_index(second_index), .rebuild_needed(rebuild_needed), .last(last)
  );

endmodule

### hdl/vpl_front.sv
`timescale 1ns / 1ps
module vpl_front #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               mode,
  input  logic [vpl_pkg::IDX_W-1:0] particle_index,
  input  logic [vpl_pkg::POS_W-1:0] pos_x,
  input  logic [vpl_pkg::POS_W-1:0] pos_y,
  input  logic [vpl_pkg::POS_W-1:0] pos_z,
  input  logic                     sweep_end,
  output logic                     head_valid,
  output vpl_pkg::item_t           head,
  input  logic                     pop
);
  import vpl_pkg::*;

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       keep;
  logic       push;

  // drop unused modes and indexes beyond the store
  always_comb begin
    keep = (mode != MODE_NONE) && (32'(particle_index) < MAX_PARTICLES);
    push = in_valid && in_ready && keep;
  end

  assign in_ready   = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot[rd_ptr];

  // hold up to two classified words for the back end
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{mode: mode, idx: particle_index, px: pos_x, py: pos_y,
                        pz: pos_z, sweep_end: sweep_end};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### hdl/vpl_minimg.sv
`timescale 1ns / 1ps
module vpl_minimg #(
  parameter int COORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [COORD_BITS-1:0]         a,
  input  logic [COORD_BITS-1:0]         b,
  input  logic [vpl_pkg::BOX_W-1:0]     box_len,
  output logic                          done,
  output logic [vpl_pkg::BOX_W-1:0]     mag
);
  import vpl_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0]    diff;
  logic [DW-1:0]    shreg;
  logic [BOX_W-1:0] len;
  logic [BOX_W-1:0] rem;
  logic [BOX_W:0]   rem_sh;
  logic [BOX_W-1:0] rem_next;
  logic [CW-1:0]    cnt;
  logic             neg;
  logic             busy;
  logic             fin;
  logic [BOX_W-1:0] r1;
  logic             wrap;

  assign diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};

  // one restoring remainder step per cycle, MSB first
  always_comb begin
    rem_sh   = {rem, shreg[DW-1]};
    rem_next = (rem_sh >= {1'b0, len}) ? BOX_W'(rem_sh - {1'b0, len}) : rem_sh[BOX_W-1:0];
    r1       = (neg && rem != '0) ? len - rem : rem;
    wrap     = {r1, 1'b0} > {1'b0, len};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= diff[DW-1] ? -diff : diff;
      neg   <= diff[DW-1];
      len   <= (box_len == '0) ? BOX_W'(1) : box_len;
      rem   <= '0;
      cnt   <= CW'(DW);
    end else if (busy) begin
      shreg <= shreg << 1;
      rem   <= rem_next;
      cnt   <= cnt - 1'b1;
    end
    // fold into the half-open image and keep the magnitude
    if (fin) mag <= wrap ? len - r1 : r1;
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start || (busy && cnt != CW'(1));
      fin  <= busy && cnt == CW'(1);
      done <= fin;
    end
  end

endmodule

### hdl/vpl_isqrt.sv
`timescale 1ns / 1ps
module vpl_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [vpl_pkg::D2_W-1:0]   x,
  output logic                       done,
  output logic [vpl_pkg::DISP_W-1:0] root
);
  import vpl_pkg::*;

  localparam int STEPS = D2_W / 2;

  logic [D2_W-1:0]  acc;
  logic [D2_W-1:0]  res;
  logic [D2_W-1:0]  bitv;
  logic [D2_W-1:0]  trial;
  logic [5:0]       cnt;
  logic             busy;

  assign trial = res + bitv;
  assign root  = res[DISP_W-1:0];

  // one result bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= x;
      res  <= '0;
      bitv <= D2_W'(1) << (D2_W - 2);
      cnt  <= 6'(STEPS);
    end else if (busy) begin
      if (acc >= trial) begin
        acc <= acc - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt - 1'b1;
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start || (busy && cnt != 6'd1);
      done <= busy && cnt == 6'd1;
    end
  end

endmodule

### hdl/vpl_back.sv
`timescale 1ns / 1ps
module vpl_back #(
  parameter int MAX_PARTICLES = 64,
  parameter int COORD_BITS    = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  vpl_pkg::cfg_t             cfg,
  input  logic                      head_valid,
  input  vpl_pkg::item_t            head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                kind,
  output logic [vpl_pkg::IDX_W-1:0] first_index,
  output logic [vpl_pkg::IDX_W-1:0] second_index,
  output logic                      rebuild_needed,
  output logic                      last
);
  import vpl_pkg::*;
  `include "verlet_pair_list_with_skin_check_macros.svh"

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int JW = AW + 1;
  localparam int TW = (JW > TOTAL_W) ? JW : TOTAL_W;
  localparam int C  = COORD_BITS;
  localparam int SQ_W = 2 * BOX_W;

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_ILAT = 12'b000000000010,
    S_JRD  = 12'b000000000100,
    S_JLAT = 12'b000000001000,
    S_RLAT = 12'b000000010000,
    S_MOD  = 12'b000000100000,
    S_SUM  = 12'b000001000000,
    S_CMP  = 12'b000010000000,
    S_ROW  = 12'b000100000000,
    S_SQRT = 12'b001000000000,
    S_UPD  = 12'b010000000000,
    S_EMIT = 12'b100000000000
  } state_t;

  state_t state;

  logic [C-1:0] cur_x_mem [MAX_PARTICLES];
  logic [C-1:0] cur_y_mem [MAX_PARTICLES];
  logic [C-1:0] cur_z_mem [MAX_PARTICLES];
  logic [C-1:0] ref_x_mem [MAX_PARTICLES];
  logic [C-1:0] ref_y_mem [MAX_PARTICLES];
  logic [C-1:0] ref_z_mem [MAX_PARTICLES];
  logic [C-1:0] cur_qx, cur_qy, cur_qz;
  logic [C-1:0] ref_qx, ref_qy, ref_qz;

  logic [C-1:0]        ax, ay, az;
  logic [IDX_W-1:0]    row_idx;
  logic                is_check;
  logic                sweep_flag;
  logic [JW-1:0]       j;
  logic [D2_W-1:0]     lc2;
  logic [D2_W-1:0]     sqx, sqy, sqz;
  logic [D2_W-1:0]     d2;
  logic [DISP_W-1:0]   disp;
  logic [DISP_W-1:0]   largest_disp;
  logic [DISP_W-1:0]   second_disp;

  logic [AW-1:0]       cur_raddr;
  logic [AW-1:0]       head_addr;
  logic [AW-1:0]       row_addr;
  logic [TW-1:0]       total_eff;
  logic                row_more;
  logic                j_more;
  logic                out_free;
  logic                mi_start;
  logic [C-1:0]        bx, by, bz;
  logic [2:0]          mi_done;
  logic [BOX_W-1:0]    mag_x, mag_y, mag_z;
  logic [SQ_W-1:0]     pxs, pys, pzs;
  logic [BOX_W:0]      lc;
  logic [SQ_W+1:0]     lc_sq;
  logic                sq_start;
  logic                sq_done;
  logic [DISP_W-1:0]   root;
  logic [DISP_W-1:0]   new_large;
  logic [DISP_W-1:0]   new_second;
  logic                verdict;

  // steer addresses, unit operands and compares
  always_comb begin
    out_free  = !out_valid || out_ready;
    pop       = (state == S_IDLE) && head_valid;
    head_addr = AW'(head.idx);
    row_addr  = AW'(row_idx);
    cur_raddr = (state == S_IDLE) ? head_addr : j[AW-1:0];
    total_eff = (TW'(cfg.total) > TW'(MAX_PARTICLES)) ? TW'(MAX_PARTICLES) : TW'(cfg.total);
    row_more  = (TW'(row_idx) + TW'(1)) < total_eff;
    j_more    = (TW'(j) + TW'(1)) < total_eff;
    mi_start  = (state == S_JLAT) || (state == S_RLAT);
    bx        = (state == S_JLAT) ? cur_qx : ref_qx;
    by        = (state == S_JLAT) ? cur_qy : ref_qy;
    bz        = (state == S_JLAT) ? cur_qz : ref_qz;
    pxs       = mag_x * mag_x;
    pys       = mag_y * mag_y;
    pzs       = mag_z * mag_z;
    lc        = {1'b0, cfg.cutoff} + {1'b0, cfg.skin};
    lc_sq     = lc * lc;
    sq_start  = (state == S_CMP) && is_check;
    if (disp > largest_disp) begin
      new_large  = disp;
      new_second = largest_disp;
    end else if (disp > second_disp) begin
      new_large  = largest_disp;
      new_second = disp;
    end else begin
      new_large  = largest_disp;
      new_second = second_disp;
    end
    verdict = ({1'b0, new_large} + {1'b0, new_second}) > (DISP_W + 1)'(cfg.skin);
  end

  vpl_minimg #(.COORD_BITS(C)) u_mi_x (
    .clk(clk), .rst(rst), .start(mi_start), .a(ax), .b(bx), .box_len(cfg.box_x),
    .done(mi_done[0]), .mag(mag_x)
  );
  vpl_minimg #(.COORD_BITS(C)) u_mi_y (
    .clk(clk), .rst(rst), .start(mi_start), .a(ay), .b(by), .box_len(cfg.box_y),
    .done(mi_done[1]), .mag(mag_y)
  );
  vpl_minimg #(.COORD_BITS(C)) u_mi_z (
    .clk(clk), .rst(rst), .start(mi_start), .a(az), .b(bz), .box_len(cfg.box_z),
    .done(mi_done[2]), .mag(mag_z)
  );

  vpl_isqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .x(d2), .done(sq_done), .root(root)
  );

  // position stores
  always_ff @(posedge clk) begin
    if (pop && head.mode == MODE_LOAD) begin
      cur_x_mem[head_addr] <= head.px[C-1:0];
      cur_y_mem[head_addr] <= head.py[C-1:0];
      cur_z_mem[head_addr] <= head.pz[C-1:0];
    end
    if (state == S_ROW && out_free) begin
      ref_x_mem[row_addr] <= ax;
      ref_y_mem[row_addr] <= ay;
      ref_z_mem[row_addr] <= az;
    end
    cur_qx <= cur_x_mem[cur_raddr];
    cur_qy <= cur_y_mem[cur_raddr];
    cur_qz <= cur_z_mem[cur_raddr];
    ref_qx <= ref_x_mem[head_addr];
    ref_qy <= ref_y_mem[head_addr];
    ref_qz <= ref_z_mem[head_addr];
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      largest_disp <= '0;
      second_disp  <= '0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (head_valid) begin
            row_idx    <= head.idx;
            sweep_flag <= head.sweep_end;
            is_check   <= (head.mode == MODE_CHECK);
            ax         <= head.px[C-1:0];
            ay         <= head.py[C-1:0];
            az         <= head.pz[C-1:0];
            if (head.mode == MODE_BUILD) state <= S_ILAT;
            else if (head.mode == MODE_CHECK) state <= S_RLAT;
          end
        end
        S_ILAT: begin
          ax    <= cur_qx;
          ay    <= cur_qy;
          az    <= cur_qz;
          lc2   <= D2_W'(lc_sq);
          j     <= JW'(row_idx) + JW'(1);
          state <= row_more ? S_JRD : S_ROW;
        end
        S_JRD:  state <= S_JLAT;
        S_JLAT: state <= S_MOD;
        S_RLAT: state <= S_MOD;
        S_MOD: begin
          if (mi_done[0]) begin
            sqx   <= D2_W'(pxs);
            sqy   <= D2_W'(pys);
            sqz   <= D2_W'(pzs);
            state <= S_SUM;
          end
        end
        S_SUM: begin
          d2    <= sqx + sqy + sqz;
          state <= S_CMP;
        end
        S_CMP: begin
          if (is_check) begin
            state <= S_SQRT;
          end else if (d2 >= lc2 || out_free) begin
            if (d2 < lc2) begin
              out_valid      <= 1'b1;
              kind           <= KIND_PAIR;
              first_index    <= row_idx;
              second_index   <= IDX_W'(j);
              rebuild_needed <= 1'b0;
              last           <= 1'b0;
            end
            j     <= j + 1'b1;
            state <= j_more ? S_JRD : S_ROW;
          end
        end
        S_ROW: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            kind           <= KIND_ROW;
            first_index    <= row_idx;
            second_index   <= '0;
            rebuild_needed <= 1'b0;
            last           <= 1'b1;
            state          <= S_IDLE;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            disp  <= root;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (!sweep_flag) begin
            largest_disp <= new_large;
            second_disp  <= new_second;
            state        <= S_IDLE;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            kind           <= KIND_VERDICT;
            first_index    <= '0;
            second_index   <= '0;
            rebuild_needed <= verdict;
            last           <= 1'b1;
            largest_disp   <= '0;
            second_disp    <= '0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `VPL_ASSERT_NOW(a_units_in_step, mi_done[0] || mi_done[1] || mi_done[2], mi_done == 3'b111, "minimum image units out of step")
  `VPL_ASSERT_NOW(a_scan_in_range, state == S_JRD, TW'(j) < total_eff, "row scan beyond particle total")
  `VPL_ASSERT_NOW(a_disp_order, 1'b1, largest_disp >= second_disp, "displacement order broken")
  `VPL_ASSERT_NEXT(a_emit_clears, state == S_EMIT && out_free, largest_disp == '0 && out_valid, "sweep end not cleared")

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import vpl_pkg::*;

  typedef struct {
    logic [1:0]       kind;
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] second;
    logic             rebuild;
    logic             last;
  } result_t;

  // Tracks the pair list state and the queue of results still owed.
  class pair_list_scoreboard;
    result_t           owed[$];
    int                errors;
    longint            cur_x[64], cur_y[64], cur_z[64];
    longint            ref_x[64], ref_y[64], ref_z[64];
    longint unsigned   box_x, box_y, box_z, cutoff, skin, total;
    longint unsigned   top_disp, next_disp;

    function new();
      errors    = 0;
      box_x     = 655360;
      box_y     = 655360;
      box_z     = 655360;
      cutoff    = 163840;
      skin      = 19661;
      total     = 64;
      top_disp  = 0;
      next_disp = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_BOX_X:  box_x  = data[BOX_W-1:0];
        CFG_BOX_Y:  box_y  = data[BOX_W-1:0];
        CFG_BOX_Z:  box_z  = data[BOX_W-1:0];
        CFG_CUTOFF: cutoff = data[LEN_W-1:0];
        CFG_SKIN:   skin   = data[LEN_W-1:0];
        CFG_TOTAL:  total  = data[TOTAL_W-1:0];
        default: ;
      endcase
    endfunction

    // Reduce a component difference into (-L/2, L/2].
    function longint fold(longint a, longint b, longint unsigned len);
      longint span, r;
      span = (len == 0) ? 1 : longint'(len);
      r = (a - b) % span;
      if (r < 0) r += span;
      if (2 * r > span) r -= span;
      return r;
    endfunction

    function longint unsigned sep2(longint ax, longint ay, longint az,
                                   longint bx, longint by, longint bz);
      longint dx, dy, dz;
      dx = fold(ax, bx, box_x);
      dy = fold(ay, by, box_y);
      dz = fold(az, bz, box_z);
      return longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    function void push(logic [1:0] k, int a, int b, bit rb, bit lst);
      result_t r;
      r.kind = k; r.first = IDX_W'(a); r.second = IDX_W'(b); r.rebuild = rb; r.last = lst;
      owed.push_back(r);
    endfunction

    // Predict the results of one accepted input word.
    function void note(item_t it);
      int               i;
      longint unsigned  lim, reach, reach2, d;
      longint           px, py, pz;
      i  = it.idx;
      px = longint'(signed'(it.px));
      py = longint'(signed'(it.py));
      pz = longint'(signed'(it.pz));
      case (it.mode)
        MODE_LOAD: begin
          cur_x[i] = px; cur_y[i] = py; cur_z[i] = pz;
        end
        MODE_BUILD: begin
          lim    = (total > 64) ? 64 : total;
          reach  = cutoff + skin;
          reach2 = reach * reach;
          for (int j = i + 1; j < lim; j++) begin
            if (sep2(cur_x[i], cur_y[i], cur_z[i], cur_x[j], cur_y[j], cur_z[j]) < reach2)
              push(KIND_PAIR, i, j, 0, 0);
          end
          ref_x[i] = cur_x[i]; ref_y[i] = cur_y[i]; ref_z[i] = cur_z[i];
          push(KIND_ROW, i, 0, 0, 1);
        end
        MODE_CHECK: begin
          d = floor_sqrt(sep2(px, py, pz, ref_x[i], ref_y[i], ref_z[i]));
          if (d > top_disp) begin
            next_disp = top_disp;
            top_disp  = d;
          end else if (d > next_disp) begin
            next_disp = d;
          end
          if (it.sweep_end) begin
            push(KIND_VERDICT, 0, 0, (top_disp + next_disp) > skin, 1);
            top_disp  = 0;
            next_disp = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check(result_t got);
      result_t want;
      if (owed.size() == 0) begin
        $display("%0t unexpected result: kind %0d first %0d second %0d", $realtime,
                 got.kind, got.first, got.second);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.kind !== want.kind) begin
        $display("%0t kind: expected %0d actual %0d", $realtime, want.kind, got.kind);
        errors++;
      end
      if (got.first !== want.first) begin
        $display("%0t first_index: expected %0d actual %0d", $realtime, want.first, got.first);
        errors++;
      end
      if (got.second !== want.second) begin
        $display("%0t second_index: expected %0d actual %0d", $realtime, want.second,
                 got.second);
        errors++;
      end
      if (got.rebuild !== want.rebuild) begin
        $display("%0t rebuild_needed: expected %0d actual %0d", $realtime, want.rebuild,
                 got.rebuild);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t last: expected %0d actual %0d", $realtime, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 0;
  logic                  in_ready;
  logic [1:0]            mode = MODE_LOAD;
  logic [IDX_W-1:0]      particle_index = '0;
  logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic                  sweep_end = 0;
  logic                  out_valid;
  logic                  out_ready = 1;
  logic [1:0]            kind;
  logic [IDX_W-1:0]      first_index, second_index;
  logic                  rebuild_needed, last;

  pair_list_scoreboard sb = new();

  // Stimulus-side knowledge of what has been loaded and latched as reference.
  bit                   loaded[64];
  bit                   has_ref[64];
  logic [POS_W-1:0]     mem_x[64], mem_y[64], mem_z[64];
  int                   sent;
  int                   burst_left;
  longint unsigned      cur_box, cur_reach;

  verlet_pair_list_with_skin_check uut (.*);

  always #2 clk = ~clk;

  // Accepted words go to the scoreboard and delivered results are checked, sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note('{mode, particle_index, pos_x, pos_y, pos_z, sweep_end});
    if (!rst && out_valid && out_ready)
      sb.check('{kind, first_index, second_index, rebuild_needed, last});
  end

  // Receiver backpressure: stretches of always ready, random, and long stalls.
  int stall_style = 0, style_left = 0, hold_left = 0;
  always @(negedge clk) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 2);
      style_left  = $urandom_range(64, 256);
    end
    style_left--;
    case (stall_style)
      0: out_ready <= 1;
      1: out_ready <= $urandom_range(0, 1);
      default: begin
        if (hold_left == 0) begin
          hold_left = out_ready ? $urandom_range(1, 20) : $urandom_range(1, 5);
          out_ready <= ~out_ready;
        end
        hold_left--;
      end
    endcase
  end

  // Send one word; the sender runs in bursts with random gaps between them.
  task automatic send(logic [1:0] m, int idx, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                      logic [POS_W-1:0] z, bit se);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid       = 1;
    mode           = m;
    particle_index = idx;
    pos_x          = x;
    pos_y          = y;
    pos_z          = z;
    sweep_end      = se;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 0;
    if (m != MODE_NONE) sent++;
  endtask

  // Hold until no result is owed, then let the block settle.
  task automatic drain();
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1;
    cfg_index = index;
    cfg_data  = data;
    sb.write_reg(index, data);
    @(negedge clk);
    cfg_we = 0;
  endtask

  // A coordinate: mostly clustered within reach, sometimes wrapped or fully random.
  function automatic logic [POS_W-1:0] pick_coord();
    longint unsigned spread;
    longint          v;
    spread = cur_reach * 2 + 1;
    if (spread > 32'h7fffffff) spread = 32'h7fffffff;
    if ($urandom_range(0, 5) == 0) return $urandom();
    v = longint'($urandom_range(0, 32'(spread)));
    if ($urandom_range(0, 3) == 0) v += (longint'($urandom_range(0, 2)) - 1) * longint'(cur_box);
    return v[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] nudge(logic [POS_W-1:0] c);
    int unsigned step;
    step = (cur_reach > 2000000) ? 2000000 : 32'(cur_reach / 8 + 1);
    if ($urandom_range(0, 7) == 0) return $urandom();
    return c + $urandom_range(0, 2 * step) - step;
  endfunction

  task automatic load(int i, logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [POS_W-1:0] z);
    mem_x[i] = x; mem_y[i] = y; mem_z[i] = z;
    loaded[i] = 1;
    send(MODE_LOAD, i, x, y, z, 0);
  endtask

  // One round: load, build every row, move a few particles, then check sweeps.
  task automatic round(int nload);
    int moves;
    for (int i = 0; i < nload; i++) begin
      load(i, pick_coord(), pick_coord(), pick_coord());
      if ($urandom_range(0, 9) == 0) send(MODE_NONE, $urandom_range(0, 63), $urandom(),
                                          $urandom(), $urandom(), $urandom_range(0, 1));
    end
    for (int i = 0; i < nload; i++) begin
      send(MODE_BUILD, i, $urandom(), $urandom(), $urandom(), $urandom_range(0, 1));
      has_ref[i] = 1;
    end
    moves = $urandom_range(0, 3);
    for (int k = 0; k < moves; k++) begin
      int i;
      i = $urandom_range(0, nload - 1);
      load(i, nudge(mem_x[i]), nudge(mem_y[i]), nudge(mem_z[i]));
    end
    repeat ($urandom_range(1, 2)) begin
      for (int i = 0; i < nload; i++)
        send(MODE_CHECK, i, nudge(mem_x[i]), nudge(mem_y[i]), nudge(mem_z[i]),
             (i == nload - 1) || ($urandom_range(0, 15) == 0));
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_box();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1;
      2: return 31'h7fffffff;
      3: return $urandom_range(1, 31'h7fffffff);
      default: return 655360 * $urandom_range(1, 20);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_len();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 30'h3fffffff;
      2: return $urandom_range(0, 30'h3fffffff);
      default: return $urandom_range(0, 262144);
    endcase
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] bx, by, bz, cut, sk;
    int                    tot, nload, rounds;
    sent       = 0;
    burst_left = 0;
    cur_box    = 655360;
    cur_reach  = 163840 + 19661;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: field extremes, ignored mode, row past total, check before sweep end.
    write_reg(CFG_TOTAL, 4);
    load(0, 32'h80000000, 32'h7fffffff, 32'h0);
    load(1, 32'h7fffffff, 32'h80000000, 32'hffffffff);
    load(2, 32'h0, 32'h0, 32'h0);
    load(3, 32'h10000, 32'h8000, 32'h0);
    load(4, 32'hffffffff, 32'h0, 32'h10000);
    send(MODE_NONE, 63, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1);
    for (int i = 0; i < 5; i++) begin
      send(MODE_BUILD, i, 0, 0, 0, 0);
      has_ref[i] = 1;
    end
    send(MODE_CHECK, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
    send(MODE_CHECK, 1, 32'h80000000, 32'h7fffffff, 32'h80000000, 0);
    send(MODE_CHECK, 2, 32'h0, 32'h0, 32'h0, 1);
    send(MODE_CHECK, 3, 32'h10000, 32'h8000, 32'h0, 1);
    send(MODE_CHECK, 4, 32'h0, 32'h0, 32'h0, 1);
    load(2, 32'h4000, 32'h0, 32'h0);
    send(MODE_CHECK, 2, 32'h4000, 32'h0, 32'h0, 1);

    // Random rounds, each under its own register setting; one round fills all 64.
    rounds = 0;
    while (sent < 370) begin
      drain();
      bx  = pick_box();
      by  = pick_box();
      bz  = pick_box();
      cut = pick_len();
      sk  = pick_len();
      if (rounds == 3) tot = 127;
      else if (rounds % 5 == 4) tot = $urandom_range(0, 1);
      else tot = $urandom_range(2, 8);
      write_reg(CFG_BOX_X, bx);
      write_reg(CFG_BOX_Y, by);
      write_reg(CFG_BOX_Z, bz);
      write_reg(CFG_CUTOFF, cut);
      write_reg(CFG_SKIN, sk);
      write_reg(CFG_TOTAL, CFG_DATA_W'(tot));
      cur_box   = (bx == 0) ? 1 : bx;
      cur_reach = cut + sk;
      nload = (tot >= 64) ? 64 : ((tot < 2 ? 2 : tot) + 1);
      round(nload);
      rounds++;
    end

    drain();
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #8000000;
    $display("tb_top failed");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/vpl_pkg.sv
hdl/vpl_front.sv
hdl/vpl_minimg.sv
hdl/vpl_isqrt.sv
hdl/vpl_back.sv
hdl/verlet_pair_list_with_skin_check.sv
dv/tb_top.sv
